>>> hdl/i2ra_pkg.sv
// i2ra_pkg: shared constants, the back-end state type and the digit glyph lookup
// for the integer to radix ascii converter
// no dependencies
package i2ra_pkg;

	localparam int VALUE_WIDTH_DEF = 32;
	localparam int RADIX_W         = 5;
	localparam int CHAR_W          = 8;
	localparam int QUEUE_DEPTH     = 2;

	localparam logic [RADIX_W-1:0] RADIX_MIN   = 5'd2;
	localparam logic [RADIX_W-1:0] RADIX_MAX   = 5'd16;
	localparam logic [RADIX_W-1:0] RADIX_RESET = 5'd10;

	localparam logic [CHAR_W-1:0] CHAR_MINUS    = 8'h2D;
	localparam logic [CHAR_W-1:0] CHAR_ZERO     = 8'h30;
	localparam logic [CHAR_W-1:0] CHAR_ALPHA_OF = 8'h37; // 'A' - 10

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_DIV,
		ST_SIGN,
		ST_EMIT
	} back_state_t;

	// digit 0..15 to '0'-'9', 'A'-'F'
	function automatic logic [CHAR_W-1:0] digit_glyph(input logic [3:0] d);
		logic [CHAR_W-1:0] code;
		if (d < 4'd10) begin
			code = CHAR_ZERO + CHAR_W'(d);
		end else begin
			code = CHAR_ALPHA_OF + CHAR_W'(d);
		end
		return code;
	endfunction

endpackage

>>> hdl/i2ra_front.sv
// i2ra_front: accepts items, splits them into sign and unsigned magnitude
// and holds them in a short queue for the back end; uses i2ra_pkg
module i2ra_front import i2ra_pkg::*; #(
	parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  logic signed [VALUE_WIDTH-1:0] value,
	output logic                          q_valid,
	output logic                          q_neg,
	output logic        [VALUE_WIDTH-1:0] q_mag,
	input  logic                          q_pop
);

	localparam int QAW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int QCW = $clog2(QUEUE_DEPTH + 1);

	logic                   neg_q [QUEUE_DEPTH];
	logic [VALUE_WIDTH-1:0] mag_q [QUEUE_DEPTH];
	logic [QAW-1:0]         wr_ptr_q;
	logic [QAW-1:0]         rd_ptr_q;
	logic [QCW-1:0]         count_q;

	logic                   push;
	logic                   pop;
	logic [VALUE_WIDTH-1:0] raw;
	logic                   cls_neg;
	logic [VALUE_WIDTH-1:0] cls_mag;

	// classification: sign and full unsigned magnitude
	assign raw     = value;
	assign cls_neg = raw[VALUE_WIDTH-1];
	assign cls_mag = cls_neg ? (~raw + 1'b1) : raw;

	assign busy    = (count_q == QCW'(QUEUE_DEPTH));
	assign push    = start && !busy;
	assign q_valid = (count_q != '0);
	assign pop     = q_pop && q_valid;
	assign q_neg   = neg_q[rd_ptr_q];
	assign q_mag   = mag_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			neg_q[wr_ptr_q] <= cls_neg;
			mag_q[wr_ptr_q] <= cls_mag;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == QAW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == QAW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

>>> hdl/i2ra_back.sv
// i2ra_back: iterative divider that peels digits off the magnitude into a digit
// store, then emits sign and digits most significant first; uses i2ra_pkg
module i2ra_back import i2ra_pkg::*; #(
	parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic [RADIX_W-1:0]     radix,
	input  logic                   q_valid,
	input  logic                   q_neg,
	input  logic [VALUE_WIDTH-1:0] q_mag,
	output logic                   q_pop,
	output logic                   strobe,
	output logic [CHAR_W-1:0]      char_code,
	output logic                   last
);

	localparam int NB  = (VALUE_WIDTH + 7) / 8;
	localparam int MW  = NB * 8;
	localparam int BIW = (NB > 1) ? $clog2(NB) : 1;
	localparam int AW  = $clog2(VALUE_WIDTH);
	localparam int CW  = $clog2(VALUE_WIDTH + 1);

	// one byte of long division by a radix of at most 16
	function automatic logic [11:0] byte_step(input logic [3:0] rin, input logic [7:0] b,
		input logic [RADIX_W-1:0] base);
		logic [4:0] t;
		logic [3:0] r;
		logic [7:0] q;
		r = rin;
		q = '0;
		for (int i = 7; i >= 0; i--) begin
			t = {r, b[i]};
			if (t >= base) begin
				r    = 4'(t - base);
				q[i] = 1'b1;
			end else begin
				r = t[3:0];
			end
		end
		return {q, r};
	endfunction

	back_state_t state_q, state_d;

	logic [MW-1:0]      mag_q;
	logic [3:0]         rem_q;
	logic [BIW-1:0]     idx_q;
	logic [BIW-1:0]     top_q;
	logic               qnz_q;
	logic [CW-1:0]      ndig_q;
	logic               neg_q;
	logic [RADIX_W-1:0] base_q;
	logic [AW-1:0]      rp_q;
	logic [3:0]         dig_mem [VALUE_WIDTH];
	logic [3:0]         rd_data_q;
	logic               strobe_q;
	logic [CHAR_W-1:0]  char_q;
	logic               last_q;

	logic [7:0]     cur_byte;
	logic [11:0]    step;
	logic [7:0]     qb;
	logic [3:0]     rnew;
	logic           pass_end;
	logic           q_zero;
	logic [CW-1:0]  ndig_nxt;
	logic [CW-1:0]  ndig_m1;
	logic           div_done;
	logic [BIW-1:0] new_top;
	logic [AW-1:0]  rd_addr;

	assign cur_byte = mag_q[idx_q*8 +: 8];
	assign step     = byte_step(rem_q, cur_byte, base_q);
	assign qb       = step[11:4];
	assign rnew     = step[3:0];
	assign pass_end = (idx_q == '0);
	assign q_zero   = !(qnz_q || (qb != '0));
	assign ndig_nxt = ndig_q + 1'b1;
	assign ndig_m1  = ndig_q - 1'b1;
	assign div_done = pass_end && (q_zero || (ndig_nxt == CW'(VALUE_WIDTH)));
	// quotient loses at most four bits a pass, so at most one byte drops
	assign new_top  = ((top_q != '0) && (mag_q[top_q*8 +: 8] == '0)) ? top_q - 1'b1 : top_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		q_pop   = 1'b0;
		rd_addr = rp_q - 1'b1;
		unique case (state_q)
			ST_IDLE: begin
				if (q_valid) begin
					q_pop   = 1'b1;
					state_d = ST_DIV;
				end
			end
			ST_DIV: begin
				if (div_done) begin
					state_d = ST_SIGN;
				end
			end
			ST_SIGN: begin
				rd_addr = ndig_m1[AW-1:0];
				state_d = ST_EMIT;
			end
			ST_EMIT: begin
				if (rp_q == '0) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// division datapath
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				mag_q  <= MW'(q_mag);
				neg_q  <= q_neg;
				base_q <= radix;
				rem_q  <= '0;
				qnz_q  <= 1'b0;
				idx_q  <= BIW'(NB - 1);
				top_q  <= BIW'(NB - 1);
				ndig_q <= '0;
			end
			ST_DIV: begin
				mag_q[idx_q*8 +: 8] <= qb;
				if (pass_end) begin
					dig_mem[ndig_q[AW-1:0]] <= rnew;
					ndig_q <= ndig_nxt;
					rem_q  <= '0;
					qnz_q  <= 1'b0;
					idx_q  <= new_top;
					top_q  <= new_top;
				end else begin
					rem_q <= rnew;
					qnz_q <= qnz_q || (qb != '0);
					idx_q <= idx_q - 1'b1;
				end
			end
			ST_SIGN: begin
				rp_q <= ndig_m1[AW-1:0];
			end
			ST_EMIT: begin
				rp_q <= rp_q - 1'b1;
			end
			default: begin
			end
		endcase
		rd_data_q <= dig_mem[rd_addr];
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			strobe_q <= 1'b0;
		end else begin
			strobe_q <= ((state_q == ST_SIGN) && neg_q) || (state_q == ST_EMIT);
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_SIGN) begin
			char_q <= CHAR_MINUS;
			last_q <= 1'b0;
		end else begin
			char_q <= digit_glyph(rd_data_q);
			last_q <= (rp_q == '0);
		end
	end

	assign strobe    = strobe_q;
	assign char_code = char_q;
	assign last      = last_q;

`ifndef NO_ASSERTIONS
	a_base_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DIV) |-> (base_q >= RADIX_MIN && base_q <= RADIX_MAX))
		else $error("divider base out of range");
	a_rem_below_base: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DIV) |-> (rem_q < base_q))
		else $error("partial remainder not below base");
	a_digits_present: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SIGN) |-> (ndig_q != '0 && ndig_q <= CW'(VALUE_WIDTH)))
		else $error("digit count out of range at emit");
	a_pop_needs_item: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> q_valid)
		else $error("pop from empty queue");
	a_gap_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		(strobe_q && last_q) |=> !strobe_q)
		else $error("character strobed straight after last");
`endif

endmodule

>>> hdl/integer_to_radix_ascii.sv
// integer_to_radix_ascii: top level, radix register, front end and back end
// depends on i2ra_pkg, i2ra_front and i2ra_back
//
// usage
//  - input: an item (value, signed) is taken at a rising edge with start high and busy low;
//    the front end classifies it and parks it in a two-entry queue, so busy rises only
//    when that queue is full
//  - radix: written at any edge with cfg_we high; values outside 2..16 are refused and
//    the previous radix is kept; it must only be written while the block is idle
//  - output: one character per cycle within an item, on char_code with strobe high
//    for exactly one cycle, '-' first for negative values, digits most significant
//    first, last high on the final character; the receiver cannot stall, every strobed
//    character is taken
//  - steps per item in the back end: a load, then for each digit one divide step per
//    magnitude byte still in play (the byte-wide divide step is the loop), then a step
//    that sets up the digit store read and also sends a leading '-', then the digits;
//    the '-' is registered once, each digit in the digit store read and result registers
//  - reset: radix returns to 10, the queue empties and the back end goes idle
module integer_to_radix_ascii import i2ra_pkg::*; #(
	parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  logic signed [VALUE_WIDTH-1:0] value,
	input  logic                          cfg_we,
	input  logic        [RADIX_W-1:0]     cfg_data,
	output logic                          strobe,
	output logic        [CHAR_W-1:0]      char_code,
	output logic                          last
);

	logic [RADIX_W-1:0]     radix_q;
	logic                   q_valid;
	logic                   q_neg;
	logic [VALUE_WIDTH-1:0] q_mag;
	logic                   q_pop;

	// radix register, out-of-range writes dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radix_q <= RADIX_RESET;
		end else if (cfg_we && (cfg_data >= RADIX_MIN) && (cfg_data <= RADIX_MAX)) begin
			radix_q <= cfg_data;
		end
	end

	// front end: accept, sign/magnitude split, item queue
	i2ra_front #(
		.VALUE_WIDTH(VALUE_WIDTH)
	) u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.value  (value),
		.q_valid(q_valid),
		.q_neg  (q_neg),
		.q_mag  (q_mag),
		.q_pop  (q_pop)
	);

	// back end: digit generation and character output
	i2ra_back #(
		.VALUE_WIDTH(VALUE_WIDTH)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.radix    (radix_q),
		.q_valid  (q_valid),
		.q_neg    (q_neg),
		.q_mag    (q_mag),
		.q_pop    (q_pop),
		.strobe   (strobe),
		.char_code(char_code),
		.last     (last)
	);

endmodule
